>>> hdl/prl_pkg.sv
// shared types and codes for the positional record list
`default_nettype none
package prl_pkg;
   typedef enum logic [2:0] {
      REQ_INSERT  = 3'd0,
      REQ_DELETE  = 3'd1,
      REQ_REPLACE = 3'd2,
      REQ_READ    = 3'd3,
      REQ_FIND    = 3'd4,
      REQ_SORT    = 3'd5
   } req_code_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_INSERT_ERR = 3'd1,
      ST_DELETE_ERR = 3'd2,
      ST_POS_ERR    = 3'd3,
      ST_NOT_FOUND  = 3'd4
   } status_code_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_FIND_RD,
      S_FIND_CMP,
      S_READ_WAIT,
      S_SORT_RDI,
      S_SORT_RDJ,
      S_SORT_CMP,
      S_SORT_WRJ,
      S_RESP
   } state_type;

   localparam int NAME_W = 160;
   localparam int ID_W   = 32;
   localparam int REC_W  = ID_W + NAME_W;

   // string compare: equal bytes up to and including the first zero byte
   function automatic logic names_match(input logic [NAME_W-1:0] a,
                                        input logic [NAME_W-1:0] b);
      logic ok;
      logic done;
      ok = 1'b1;
      done = 1'b0;
      for (int k = 0; k < 20; k++) begin
         if (!done) begin
            if (a[k*8 +: 8] != b[k*8 +: 8]) begin
               ok = 1'b0;
               done = 1'b1;
            end else if (a[k*8 +: 8] == 8'd0) begin
               done = 1'b1;
            end
         end
      end
      return ok;
   endfunction
endpackage
`default_nettype wire

>>> hdl/prl_if.sv
// valid/ready channel interfaces for requests and responses
`default_nettype none
interface prl_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  req_type;
   logic [6:0]  position;
   logic signed [31:0] entry_id;
   logic [63:0] name_word0;
   logic [63:0] name_word1;
   logic [31:0] name_word2;
   modport source (output valid, req_type, position, entry_id, name_word0, name_word1,
                   name_word2, input ready);
   modport sink (input valid, req_type, position, entry_id, name_word0, name_word1,
                 name_word2, output ready);
endinterface

interface prl_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [5:0]  result_index;
   logic [6:0]  list_length;
   logic        list_empty;
   logic        list_full;
   logic signed [31:0] out_id;
   logic [63:0] out_name0;
   logic [63:0] out_name1;
   logic [31:0] out_name2;
   modport source (output valid, status, result_index, list_length, list_empty, list_full,
                   out_id, out_name0, out_name1, out_name2, input ready);
   modport sink (input valid, status, result_index, list_length, list_empty, list_full,
                 out_id, out_name0, out_name1, out_name2, output ready);
endinterface
`default_nettype wire

>>> hdl/prl_mem.sv
// record memory: one write port, one registered read port
`default_nettype none
module prl_mem #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [AW-1:0]            waddr,
   input  wire logic [prl_pkg::REC_W-1:0] wdata,
   input  wire logic [AW-1:0]            raddr,
   output logic      [prl_pkg::REC_W-1:0] rdata_ff
);
   logic [prl_pkg::REC_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end
endmodule
`default_nettype wire

>>> hdl/positional_record_list_core.sv
// top level of the positional record list engine
//
//  channel | dir | payload
//  req     | in  | req_type position entry_id name_word0..2
//  rsp     | out | status result_index list_length list_empty list_full out_id out_name0..2
//
// one transaction in flight; the next request is taken once the response is accepted
// insert/delete shift one record per S_SHIFT_RD/S_SHIFT_WR pair; replace writes on accept;
// read passes through S_READ_WAIT; find reads, then compares, each record in turn
// sort reads record i, then reads and compares each later record; swaps add no states
// records sit in a single-port-read memory, which sets every walk's pace
// synchronous reset clears count and control; memory contents are not cleared
// response holds while rsp.ready is low
`default_nettype none
module positional_record_list_core #(
   parameter int CAPACITY = 64
) (
   input wire logic clock,
   input wire logic reset,
   prl_req_if.sink   req,
   prl_rsp_if.source rsp
);
   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   prl_pkg::state_type state_ff, state_in;

   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] i_ff, i_in;       // walk index / sort outer index
   logic [CW-1:0] j_ff, j_in;       // sort inner index
   logic [CW-1:0] pos_ff, pos_in;
   logic [2:0]    op_ff, op_in;
   logic [prl_pkg::REC_W-1:0] rec_ff, rec_in;   // request record
   logic [prl_pkg::REC_W-1:0] hold_ff, hold_in; // record held for sort index i (smallest id so far)

   logic [2:0]  st_ff, st_in;
   logic [5:0]  ridx_ff, ridx_in;
   logic [prl_pkg::REC_W-1:0] orec_ff, orec_in;
   logic        rv_ff, rv_in;

   logic                      we;
   logic [AW-1:0]             waddr, raddr;
   logic [prl_pkg::REC_W-1:0] wdata, rdata;

   prl_mem #(.DEPTH(CAPACITY), .AW(AW)) u_mem (
      .clock(clock), .we(we), .waddr(waddr), .wdata(wdata),
      .raddr(raddr), .rdata_ff(rdata)
   );

   logic [CW-1:0] pos_ext;
   assign pos_ext = (CW >= 7) ? CW'(req.position) : CW'(req.position);
   logic pos_big;
   // position beyond the count field range fails insert, delete, replace and read
   assign pos_big = (CW < 7) ? ((req.position >> CW) != 7'd0) : 1'b0;

   assign req.ready = (state_ff == prl_pkg::S_IDLE) && !rv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= prl_pkg::S_IDLE;
         count_ff <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rv_ff    <= rv_in;
      end
      i_ff <= i_in; j_ff <= j_in; pos_ff <= pos_in; op_ff <= op_in;
      rec_ff <= rec_in; hold_ff <= hold_in;
      st_ff <= st_in; ridx_ff <= ridx_in; orec_ff <= orec_in;
   end

   always_comb begin
      logic signed [31:0] a_id, b_id;
      state_in = state_ff; count_in = count_ff; rv_in = rv_ff;
      i_in = i_ff; j_in = j_ff; pos_in = pos_ff; op_in = op_ff;
      rec_in = rec_ff; hold_in = hold_ff;
      st_in = st_ff; ridx_in = ridx_ff; orec_in = orec_ff;
      we = 1'b0; waddr = '0; wdata = rec_ff; raddr = '0;
      a_id = hold_ff[prl_pkg::REC_W-1 -: 32];
      b_id = rdata[prl_pkg::REC_W-1 -: 32];

      if (rv_ff && rsp.ready) rv_in = 1'b0;

      case (state_ff)
         prl_pkg::S_IDLE: begin
            if (req.valid && req.ready) begin
               op_in  = req.req_type;
               pos_in = pos_ext;
               rec_in = {req.entry_id, req.name_word2, req.name_word1, req.name_word0};
               st_in  = prl_pkg::ST_OK;
               ridx_in = '0;
               orec_in = '0;
               state_in = prl_pkg::S_RESP;
               case (req.req_type)
                  prl_pkg::REQ_INSERT: begin
                     if (count_ff >= CW'(CAPACITY) || pos_big || pos_ext > count_ff)
                        st_in = prl_pkg::ST_INSERT_ERR;
                     else begin
                        i_in = count_ff;
                        state_in = prl_pkg::S_SHIFT_RD;
                     end
                  end
                  prl_pkg::REQ_DELETE: begin
                     if (count_ff == '0 || pos_big || pos_ext >= count_ff)
                        st_in = prl_pkg::ST_DELETE_ERR;
                     else begin
                        i_in = pos_ext;
                        state_in = prl_pkg::S_SHIFT_RD;
                     end
                  end
                  prl_pkg::REQ_REPLACE: begin
                     if (pos_big || pos_ext >= count_ff) st_in = prl_pkg::ST_POS_ERR;
                     else begin
                        we = 1'b1; waddr = AW'(pos_ext);
                        wdata = {req.entry_id, req.name_word2, req.name_word1,
                                 req.name_word0};
                     end
                  end
                  prl_pkg::REQ_READ: begin
                     if (pos_big || pos_ext >= count_ff) st_in = prl_pkg::ST_POS_ERR;
                     else begin
                        raddr = AW'(pos_ext);
                        state_in = prl_pkg::S_READ_WAIT;
                     end
                  end
                  prl_pkg::REQ_FIND: begin
                     st_in = prl_pkg::ST_NOT_FOUND;
                     i_in = '0;
                     if (count_ff != '0) state_in = prl_pkg::S_FIND_RD;
                  end
                  prl_pkg::REQ_SORT: begin
                     i_in = '0;
                     if (count_ff != '0) state_in = prl_pkg::S_SORT_RDI;
                  end
                  default: ;
               endcase
            end
         end
         prl_pkg::S_READ_WAIT: begin
            orec_in = rdata;
            state_in = prl_pkg::S_RESP;
         end
         prl_pkg::S_SHIFT_RD: begin
            if (op_ff == prl_pkg::REQ_INSERT) begin
               if (i_ff == pos_ff) begin
                  we = 1'b1; waddr = AW'(pos_ff); wdata = rec_ff;
                  count_in = count_ff + CW'(1);
                  state_in = prl_pkg::S_RESP;
               end else begin
                  raddr = AW'(i_ff - CW'(1));
                  state_in = prl_pkg::S_SHIFT_WR;
               end
            end else begin
               if (i_ff + CW'(1) >= count_ff) begin
                  count_in = count_ff - CW'(1);
                  state_in = prl_pkg::S_RESP;
               end else begin
                  raddr = AW'(i_ff + CW'(1));
                  state_in = prl_pkg::S_SHIFT_WR;
               end
            end
         end
         prl_pkg::S_SHIFT_WR: begin
            we = 1'b1; waddr = AW'(i_ff); wdata = rdata;
            i_in = (op_ff == prl_pkg::REQ_INSERT) ? i_ff - CW'(1) : i_ff + CW'(1);
            state_in = prl_pkg::S_SHIFT_RD;
         end
         prl_pkg::S_FIND_RD: begin
            raddr = AW'(i_ff);
            state_in = prl_pkg::S_FIND_CMP;
         end
         prl_pkg::S_FIND_CMP: begin
            if (rdata[prl_pkg::REC_W-1 -: 32] == rec_ff[prl_pkg::REC_W-1 -: 32] &&
                prl_pkg::names_match(rdata[prl_pkg::NAME_W-1:0],
                                     rec_ff[prl_pkg::NAME_W-1:0])) begin
               st_in = prl_pkg::ST_OK;
               ridx_in = 6'(i_ff);
               state_in = prl_pkg::S_RESP;
            end else if (i_ff + CW'(1) >= count_ff) begin
               state_in = prl_pkg::S_RESP;
            end else begin
               i_in = i_ff + CW'(1);
               state_in = prl_pkg::S_FIND_RD;
            end
         end
         prl_pkg::S_SORT_RDI: begin
            // fetch record i; inner walk starts past i (j == i never swaps)
            raddr = AW'(i_ff);
            j_in = i_ff + CW'(1);
            state_in = prl_pkg::S_SORT_RDJ;
         end
         prl_pkg::S_SORT_RDJ: begin
            if (j_ff == i_ff + CW'(1)) hold_in = rdata;
            if (j_ff >= count_ff) begin
               we = 1'b1; waddr = AW'(i_ff);
               wdata = (j_ff == i_ff + CW'(1)) ? rdata : hold_ff;
               if (i_ff + CW'(1) >= count_ff) state_in = prl_pkg::S_RESP;
               else begin
                  i_in = i_ff + CW'(1);
                  state_in = prl_pkg::S_SORT_RDI;
               end
            end else begin
               raddr = AW'(j_ff);
               state_in = prl_pkg::S_SORT_CMP;
            end
         end
         prl_pkg::S_SORT_CMP: begin
            if (a_id > b_id) begin
               // hold takes j's record, j gets the old hold
               we = 1'b1; waddr = AW'(j_ff); wdata = hold_ff;
               hold_in = rdata;
            end
            j_in = j_ff + CW'(1);
            state_in = prl_pkg::S_SORT_WRJ;
         end
         prl_pkg::S_SORT_WRJ: begin
            state_in = prl_pkg::S_SORT_RDJ;
         end
         prl_pkg::S_RESP: begin
            rv_in = 1'b1;
            state_in = prl_pkg::S_IDLE;
         end
         default: state_in = prl_pkg::S_IDLE;
      endcase
   end

   // response register holds results; count reflects post-request length
   logic [CW-1:0] len_ff;
   always_ff @(posedge clock) begin
      if (state_ff == prl_pkg::S_RESP) len_ff <= count_ff;
   end

   assign rsp.valid        = rv_ff;
   assign rsp.status       = st_ff;
   assign rsp.result_index = ridx_ff;
   assign rsp.list_length  = 7'(len_ff);
   assign rsp.list_empty   = (len_ff == '0);
   assign rsp.list_full    = (len_ff >= CW'(CAPACITY));
   assign rsp.out_id       = orec_ff[prl_pkg::REC_W-1 -: 32];
   assign rsp.out_name2    = orec_ff[159:128];
   assign rsp.out_name1    = orec_ff[127:64];
   assign rsp.out_name0    = orec_ff[63:0];
endmodule
`default_nettype wire
